// File: design/schd_pkg.sv
// Shared types, codes and constants for the self-calibrating hysteresis detector.
// No dependencies; every design file imports this package.
package schd_pkg;

	// Default width of a sensor sample
	localparam int SAMPLE_BITS_DEF = 10;

	// Configuration register: log2 of the calibration sample count
	localparam int              CFG_W          = 4;
	localparam logic [CFG_W-1:0] CALIB_LOG2_RST = 4'd12;
	localparam int              CALIB_LOG2_MAX = 13;

	// Calibration sample counter, saturating
	localparam int CNT_W = 14;

	// Level codes
	localparam logic [1:0] LVL_INIT   = 2'd0;
	localparam logic [1:0] LVL_BRIGHT = 2'd1;
	localparam logic [1:0] LVL_DARK   = 2'd2;

	// Event codes
	localparam logic [1:0] EVT_NONE   = 2'd0;
	localparam logic [1:0] EVT_BRIGHT = 2'd1;
	localparam logic [1:0] EVT_DARK   = 2'd2;

	// Calibration sequencer states
	typedef enum logic [2:0] {
		CS_ACCUM,
		CS_THR_MUL,
		CS_THR_LOAD,
		CS_HYS_MUL,
		CS_HYS_LOAD,
		CS_EMIT
	} cal_state_t;

	// Top level to calibration unit
	typedef struct packed {
		logic req;       // sample waiting in the input stage, calibration open
		logic out_free;  // result register can take a transfer this cycle
	} cal_ctrl_t;

	// Calibration unit to top level
	typedef struct packed {
		logic done;  // threshold and hysteresis are valid
		logic emit;  // the input-stage sample completes this cycle
	} cal_status_t;

	// Detector result for the sample in the input stage
	typedef struct packed {
		logic [1:0] level;
		logic [1:0] evt;
		logic       led;
	} det_res_t;

	// Width of the hysteresis margin: largest value is half scale over ten
	function automatic int hyst_width(int sb);
		int half_max;
		half_max = ((1 << sb) - 1) >> 1;
		return $clog2(half_max / 10 + 1);
	endfunction

endpackage

// File: design/schd_calib.sv
// Calibration unit: accumulates samples, then derives threshold and hysteresis
// through a shared divide-by-ten reciprocal multiplier. Depends on schd_pkg.
module schd_calib #(
	parameter int SampleBits = schd_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  logic                                         cfg_wen,
	input  logic [schd_pkg::CFG_W-1:0]                   cfg_wdata,
	input  logic [SampleBits-1:0]                        sample,
	input  schd_pkg::cal_ctrl_t                          ctrl,
	output schd_pkg::cal_status_t                        status,
	output logic [SampleBits-1:0]                        threshold,
	output logic [schd_pkg::hyst_width(SampleBits)-1:0] hysteresis
);
	import schd_pkg::*;

	localparam int HystW = hyst_width(SampleBits);
	localparam int SumW  = SampleBits + CALIB_LOG2_MAX;
	// dividend holds up to nine times full scale
	localparam int DivW  = SampleBits + 4;
	localparam int DivK  = DivW + 3;
	localparam int ProdW = 2 * DivW;
	localparam int QuotW = ProdW - DivK;
	// ceil(2^DivK / 10): exact floor division for dividends below 2^DivW
	localparam longint unsigned RecipL = ((64'd1 << DivK) + 64'd9) / 64'd10;
	localparam logic [DivW-1:0] Recip = RecipL[DivW-1:0];
	localparam logic [SampleBits-1:0] SampleMax  = '1;
	localparam logic [SampleBits-1:0] SampleHalf = SampleMax >> 1;
	localparam logic [CFG_W-1:0]      ShiftMax   = CFG_W'(CALIB_LOG2_MAX);

	cal_state_t             state_q, state_d;
	logic [CFG_W-1:0]       calib_log2_q;
	logic [CFG_W-1:0]       shift;
	logic [CNT_W-1:0]       cnt_q, cnt_inc, limit;
	logic [SumW-1:0]        sum_q, sum_inc, avg_full;
	logic [SampleBits-1:0]  avg_sat;
	logic [DivW-1:0]        dividend_q, dividend_avg, dividend_hop;
	logic [ProdW-1:0]       prod_q;
	logic [QuotW-1:0]       quot;
	logic [SampleBits-1:0]  thr_next, hop;
	logic [SampleBits-1:0]  threshold_q;
	logic [HystW-1:0]       hysteresis_q;
	logic                   done_q;
	logic                   finish;
	logic                   acc_en, avg_ld, mul_en, thr_ld, hys_ld, emit, done_set;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			calib_log2_q <= CALIB_LOG2_RST;
		end else if (cfg_wen) begin
			calib_log2_q <= cfg_wdata;
		end
	end

	// Count in force; codes above the maximum act as the maximum
	assign shift    = (calib_log2_q > ShiftMax) ? ShiftMax : calib_log2_q;
	assign limit    = CNT_W'(1) << shift;
	assign cnt_inc  = (cnt_q == '1) ? cnt_q : cnt_q + 1'b1;
	assign sum_inc  = sum_q + SumW'(sample);
	assign finish   = (cnt_inc >= limit);

	// Average with saturation to full scale, then times nine
	assign avg_full     = sum_inc >> shift;
	assign avg_sat      = (|avg_full[SumW-1:SampleBits]) ? SampleMax
	                                                      : avg_full[SampleBits-1:0];
	assign dividend_avg = (DivW'(avg_sat) << 3) + DivW'(avg_sat);

	// Quotient of the last reciprocal multiply
	assign quot     = prod_q[ProdW-1:DivK];
	assign thr_next = quot[SampleBits-1:0];
	assign hop      = (thr_next > SampleHalf) ? (SampleMax - thr_next) : thr_next;
	assign dividend_hop = DivW'(hop);

	// Sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CS_ACCUM;
		end else begin
			state_q <= state_d;
		end
	end

	// Sequencer next state and strobes
	always_comb begin
		state_d  = state_q;
		acc_en   = 1'b0;
		avg_ld   = 1'b0;
		mul_en   = 1'b0;
		thr_ld   = 1'b0;
		hys_ld   = 1'b0;
		emit     = 1'b0;
		done_set = 1'b0;
		case (state_q)
			CS_ACCUM: begin
				if (ctrl.req) begin
					if (finish) begin
						acc_en  = 1'b1;
						avg_ld  = 1'b1;
						state_d = CS_THR_MUL;
					end else if (ctrl.out_free) begin
						acc_en = 1'b1;
						emit   = 1'b1;
					end
				end
			end
			CS_THR_MUL: begin
				mul_en  = 1'b1;
				state_d = CS_THR_LOAD;
			end
			CS_THR_LOAD: begin
				thr_ld  = 1'b1;
				state_d = CS_HYS_MUL;
			end
			CS_HYS_MUL: begin
				mul_en  = 1'b1;
				state_d = CS_HYS_LOAD;
			end
			CS_HYS_LOAD: begin
				hys_ld  = 1'b1;
				state_d = CS_EMIT;
			end
			CS_EMIT: begin
				if (ctrl.out_free) begin
					emit     = 1'b1;
					done_set = 1'b1;
					state_d  = CS_ACCUM;
				end
			end
			default: begin
				state_d = CS_ACCUM;
			end
		endcase
	end

	// Accumulator, counter and derived values
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q        <= '0;
			sum_q        <= '0;
			threshold_q  <= '0;
			hysteresis_q <= '0;
			done_q       <= 1'b0;
		end else begin
			if (acc_en) begin
				cnt_q <= cnt_inc;
				sum_q <= sum_inc;
			end
			if (thr_ld) begin
				threshold_q <= thr_next;
			end
			if (hys_ld) begin
				hysteresis_q <= quot[HystW-1:0];
			end
			if (done_set) begin
				done_q <= 1'b1;
			end
		end
	end

	// Divider operand and shared reciprocal multiplier
	always_ff @(posedge clk) begin
		if (avg_ld) begin
			dividend_q <= dividend_avg;
		end else if (thr_ld) begin
			dividend_q <= dividend_hop;
		end
		if (mul_en) begin
			prod_q <= dividend_q * Recip;
		end
	end

	assign status.done = done_q;
	assign status.emit = emit;
	assign threshold   = threshold_q;
	assign hysteresis  = hysteresis_q;

endmodule

// File: design/schd_detect.sv
// Hysteresis comparator: level and LED state, brighten and darken events.
// Depends on schd_pkg.
module schd_detect #(
	parameter int SampleBits = schd_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  logic                                         fire,
	input  logic [SampleBits-1:0]                        sample,
	input  logic [SampleBits-1:0]                        threshold,
	input  logic [schd_pkg::hyst_width(SampleBits)-1:0] hysteresis,
	output schd_pkg::det_res_t                           res
);
	import schd_pkg::*;

	logic [1:0]            level_q, level_d;
	logic                  led_q, led_d;
	logic [1:0]            evt;
	logic [SampleBits:0]   upper, sample_up;
	logic                  above, below;

	// Band edges, one bit wider so nothing wraps
	assign upper     = {1'b0, threshold} + (SampleBits+1)'(hysteresis);
	assign sample_up = {1'b0, sample} + (SampleBits+1)'(hysteresis);
	assign above     = ({1'b0, sample} > upper);
	assign below     = (sample_up < {1'b0, threshold});

	// Next level, event on entry, LED follows the event
	always_comb begin
		level_d = level_q;
		if (above) begin
			level_d = LVL_BRIGHT;
		end else if (below) begin
			level_d = LVL_DARK;
		end
		evt   = EVT_NONE;
		led_d = led_q;
		if (level_q != LVL_BRIGHT && level_d == LVL_BRIGHT) begin
			evt   = EVT_BRIGHT;
			led_d = 1'b0;
		end else if (level_q != LVL_DARK && level_d == LVL_DARK) begin
			evt   = EVT_DARK;
			led_d = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= LVL_INIT;
			led_q   <= 1'b0;
		end else if (fire) begin
			level_q <= level_d;
			led_q   <= led_d;
		end
	end

	assign res.level = level_d;
	assign res.evt   = evt;
	assign res.led   = led_d;

endmodule

// File: design/self_calibrating_hysteresis_detector_unit.sv
// Top level of the self-calibrating hysteresis detector: input stage,
// result register and handshakes. Depends on schd_pkg, schd_calib, schd_detect.
//
// One sample in, one result out. After reset the first 2^calib_log2 samples
// (codes above 13 act as 13) are averaged; their results carry calibrating=1
// and zero threshold and hysteresis, except the closing sample, whose result
// shows the freshly derived values. From then on each sample is compared
// against threshold +/- hysteresis and level, event and LED follow. A sample
// sits in the input register until its result is registered in the output
// register, so one transfer per clock is sustained while the result side does
// not stall and calibration is not closing. The closing sample stays in the
// input stage through the sequencer states and while the result side stalls:
// the threshold and then the hysteresis each take a multiply and a load state on
// the shared divide-by-ten reciprocal multiplier, and the closing result then
// goes from the emit state to the result register. calib_log2 is only taken
// into account until calibration ends; later writes have no effect until reset.
module self_calibrating_hysteresis_detector_unit #(
	parameter int SampleBits = schd_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	// configuration
	input  logic                                         cfg_wen,
	input  logic [schd_pkg::CFG_W-1:0]                   cfg_wdata,
	// sample channel
	input  logic                                         in_valid,
	output logic                                         in_stall,
	input  logic [SampleBits-1:0]                        sample,
	// result channel
	output logic                                         out_valid,
	input  logic                                         out_stall,
	output logic                                         calibrating,
	output logic [1:0]                                   level,
	output logic [1:0]                                   event_res,
	output logic                                         led,
	output logic [SampleBits-1:0]                        threshold_now,
	output logic [schd_pkg::hyst_width(SampleBits)-1:0] hysteresis_now
);
	import schd_pkg::*;

	localparam int HystW = hyst_width(SampleBits);

	logic                  valid_s1;
	logic [SampleBits-1:0] sample_s1;
	logic                  out_valid_q;
	logic                  calibrating_q;
	logic [1:0]            level_q;
	logic [1:0]            event_q;
	logic                  led_q;
	logic [SampleBits-1:0] thr_q;
	logic [HystW-1:0]      hyst_q;

	logic                  out_free;
	logic                  det_fire;
	logic                  s1_done;
	logic                  in_take;
	cal_ctrl_t             cal_ctrl;
	cal_status_t           cal_st;
	det_res_t              det_res;
	logic [SampleBits-1:0] threshold;
	logic [HystW-1:0]      hysteresis;

	// Handshake control
	assign out_free = !out_valid_q || !out_stall;
	assign det_fire = valid_s1 && cal_st.done && out_free;
	assign s1_done  = det_fire || cal_st.emit;
	assign in_stall = valid_s1 && !s1_done;
	assign in_take  = in_valid && !in_stall;

	assign cal_ctrl.req      = valid_s1 && !cal_st.done;
	assign cal_ctrl.out_free = out_free;

	// Input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (s1_done) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			sample_s1 <= sample;
		end
	end

	schd_calib #(
		.SampleBits (SampleBits)
	) u_calib (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wen    (cfg_wen),
		.cfg_wdata  (cfg_wdata),
		.sample     (sample_s1),
		.ctrl       (cal_ctrl),
		.status     (cal_st),
		.threshold  (threshold),
		.hysteresis (hysteresis)
	);

	schd_detect #(
		.SampleBits (SampleBits)
	) u_detect (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (det_fire),
		.sample     (sample_s1),
		.threshold  (threshold),
		.hysteresis (hysteresis),
		.res        (det_res)
	);

	// Result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_done) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result register payload
	always_ff @(posedge clk) begin
		if (s1_done) begin
			thr_q  <= threshold;
			hyst_q <= hysteresis;
			if (det_fire) begin
				calibrating_q <= 1'b0;
				level_q       <= det_res.level;
				event_q       <= det_res.evt;
				led_q         <= det_res.led;
			end else begin
				calibrating_q <= 1'b1;
				level_q       <= LVL_INIT;
				event_q       <= EVT_NONE;
				led_q         <= 1'b0;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign calibrating    = calibrating_q;
	assign level          = level_q;
	assign event_res      = event_q;
	assign led            = led_q;
	assign threshold_now  = thr_q;
	assign hysteresis_now = hyst_q;

`ifndef SYNTH
	// Calibration results carry no level, event or LED activity
	a_cal_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && calibrating |-> level == LVL_INIT && event_res == EVT_NONE && !led)
		else $error("calibration result with detector activity");

	// A brighten event lands in bright with the LED off
	a_bright: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_res == EVT_BRIGHT |-> level == LVL_BRIGHT && !led)
		else $error("brighten event inconsistent with level or LED");

	// A darken event lands in dark with the LED on
	a_dark: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_res == EVT_DARK |-> level == LVL_DARK && led)
		else $error("darken event inconsistent with level or LED");

	// Calibration closes only together with the transfer of its last sample
	a_done_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(cal_st.done) |-> $past(cal_st.emit) && out_valid && calibrating)
		else $error("calibration closed without its result");
`endif

endmodule

// File: dv/schd_level_checker.sv
`timescale 1ns / 100ps
// Result checker for the self-calibrating hysteresis detector: watches the register
// port and both transfer channels, predicts every result and compares it.
// Depends on schd_pkg only.
module schd_level_checker #(
	parameter int SB = schd_pkg::SAMPLE_BITS_DEF,
	parameter int HW = schd_pkg::hyst_width(SB)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wen,
	input  logic [schd_pkg::CFG_W-1:0] cfg_wdata,
	input  logic                       in_valid,
	input  logic                       in_stall,
	input  logic [SB-1:0]              sample,
	input  logic                       out_valid,
	input  logic                       out_stall,
	input  logic                       calibrating,
	input  logic [1:0]                 level,
	input  logic [1:0]                 event_res,
	input  logic                       led,
	input  logic [SB-1:0]              threshold_now,
	input  logic [HW-1:0]              hysteresis_now,
	output int                         mismatches,
	output int                         pending,
	output int                         n_results,
	output int                         n_calib,
	output int                         n_bright,
	output int                         n_dark,
	output int                         thr_pred,
	output int                         hys_pred
);
	import schd_pkg::*;

	localparam longint unsigned SMAX  = (1 << SB) - 1;
	localparam longint unsigned SHALF = SMAX >> 1;
	// threshold is nine tenths of the average
	localparam int unsigned THR_NUM = 9;
	localparam int unsigned THR_DEN = 10;
	localparam int unsigned HYS_DEN = 10;
	localparam int MAX_REPORTS = 30;

	typedef struct packed {
		logic          calib;
		logic [1:0]    lvl;
		logic [1:0]    evt;
		logic          led;
		logic [SB-1:0] thr;
		logic [HW-1:0] hys;
	} light_res_t;

	// predictor state
	logic [CFG_W-1:0] calib_log2_q;
	logic             cal_done;
	logic [CNT_W-1:0] cal_cnt;
	longint unsigned  cal_sum;
	logic [SB-1:0]    thr_q;
	logic [HW-1:0]    hys_q;
	logic [1:0]       lvl_q;
	logic             led_q;

	light_res_t awaited_results[$];

	// Moves the detector on by one sample and returns the result it gives
	function automatic light_res_t advance_detector(input logic [SB-1:0] s);
		light_res_t      r;
		int unsigned     shift;
		longint unsigned avg;
		longint unsigned t;
		logic [1:0]      nxt;
		r = '0;
		r.evt = EVT_NONE;
		if (!cal_done) begin
			// codes above the maximum act as the maximum
			shift = (calib_log2_q > CALIB_LOG2_MAX) ? CALIB_LOG2_MAX : calib_log2_q;
			r.calib = 1'b1;
			cal_sum += s;
			if (cal_cnt != '1)
				cal_cnt++;
			if (cal_cnt >= (1 << shift)) begin
				avg = cal_sum >> shift;
				if (avg > SMAX)
					avg = SMAX;
				t = (avg * THR_NUM) / THR_DEN;
				thr_q = SB'(t);
				hys_q = HW'((t > SHALF) ? (SMAX - t) / HYS_DEN : t / HYS_DEN);
				cal_done = 1'b1;
			end
		end else begin
			nxt = lvl_q;
			if (int'(s) > int'(thr_q) + int'(hys_q))
				nxt = LVL_BRIGHT;
			else if (int'(s) + int'(hys_q) < int'(thr_q))
				nxt = LVL_DARK;
			if (lvl_q != LVL_BRIGHT && nxt == LVL_BRIGHT) begin
				r.evt = EVT_BRIGHT;
				led_q = 1'b0;
			end else if (lvl_q != LVL_DARK && nxt == LVL_DARK) begin
				r.evt = EVT_DARK;
				led_q = 1'b1;
			end
			lvl_q = nxt;
		end
		r.lvl = lvl_q;
		r.led = led_q;
		r.thr = thr_q;
		r.hys = hys_q;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		light_res_t want;
		light_res_t got;
		if (!arst_n) begin
			calib_log2_q = CALIB_LOG2_RST;
			cal_done = 1'b0;
			cal_cnt = '0;
			cal_sum = 0;
			thr_q = '0;
			hys_q = '0;
			lvl_q = LVL_INIT;
			led_q = 1'b0;
			awaited_results.delete();
			mismatches <= 0;
			pending <= 0;
			n_results <= 0;
			n_calib <= 0;
			n_bright <= 0;
			n_dark <= 0;
			thr_pred <= 0;
			hys_pred <= 0;
		end else begin
			// register write
			if (cfg_wen)
				calib_log2_q = cfg_wdata;

			// sample transfer: predict its result
			if (in_valid && !in_stall) begin
				want = advance_detector(sample);
				awaited_results.push_back(want);
				if (want.calib)
					n_calib <= n_calib + 1;
			end

			// result transfer: compare with the oldest prediction
			if (out_valid && !out_stall) begin
				got = {calibrating, level, event_res, led, threshold_now, hysteresis_now};
				n_results <= n_results + 1;
				if (got.evt == EVT_BRIGHT)
					n_bright <= n_bright + 1;
				if (got.evt == EVT_DARK)
					n_dark <= n_dark + 1;
				if (awaited_results.size() == 0) begin
					mismatches <= mismatches + 1;
					if (mismatches < MAX_REPORTS)
						$display("%0t: result transfer with none awaited", $time);
				end else begin
					want = awaited_results.pop_front();
					if (got !== want) begin
						mismatches <= mismatches + 1;
						if (mismatches < MAX_REPORTS)
							$display({"%0t: result %0d differs: expected cal=%0d lvl=%0d evt=%0d ",
								"led=%0d thr=%0d hys=%0d, actual cal=%0d lvl=%0d evt=%0d ",
								"led=%0d thr=%0d hys=%0d"}, $time, n_results,
								want.calib, want.lvl, want.evt, want.led, want.thr, want.hys,
								got.calib, got.lvl, got.evt, got.led, got.thr, got.hys);
					end
				end
			end

			pending <= awaited_results.size();
			thr_pred <= int'(thr_q);
			hys_pred <= int'(hys_q);
		end
	end

endmodule

// File: dv/self_calibrating_hysteresis_detector_unit_tb.sv
`timescale 1ns / 100ps
// Testbench top for the self-calibrating hysteresis detector: clock, reset, sample
// and register stimulus, receiver stalls, watchdog and verdict.
// Depends on schd_pkg, the detector RTL and schd_level_checker.
module self_calibrating_hysteresis_detector_unit_tb;
	import schd_pkg::*;

	localparam int SB = SAMPLE_BITS_DEF;
	localparam int HW = hyst_width(SB);
	localparam int SMAX = (1 << SB) - 1;
	localparam int RANDOM_ITEMS = 1230;
	localparam int QUIET_ITEMS = 150;
	localparam int IDLE_LIMIT = 1000;
	localparam int HOLD_CYCLES = 60;
	localparam int SETTLE_CYCLES = 8;
	localparam int DRAIN_CYCLES = 10;

	// register codes used besides the package ones
	localparam logic [CFG_W-1:0] LOG2_TOP   = 4'd15;
	localparam logic [CFG_W-1:0] LOG2_SHORT = 4'd2;
	localparam logic [CFG_W-1:0] LOG2_ZERO  = 4'd0;
	localparam logic [CFG_W-1:0] LOG2_MAX   = CFG_W'(CALIB_LOG2_MAX);

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_wen = 1'b0;
	logic [CFG_W-1:0] cfg_wdata = '0;
	logic             in_valid = 1'b0;
	logic [SB-1:0]    sample = '0;
	logic             out_stall = 1'b0;

	wire          in_stall;
	wire          out_valid;
	wire          calibrating;
	wire [1:0]    level;
	wire [1:0]    event_res;
	wire          led;
	wire [SB-1:0] threshold_now;
	wire [HW-1:0] hysteresis_now;

	int mismatches, pending, n_results, n_calib, n_bright, n_dark, thr_pred, hys_pred;

	bit quiet = 1'b0;
	int hold_reqs = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int burst_left = 0;
	int idle_cycles = 0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	self_calibrating_hysteresis_detector_unit u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wen        (cfg_wen),
		.cfg_wdata      (cfg_wdata),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.sample         (sample),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.calibrating    (calibrating),
		.level          (level),
		.event_res      (event_res),
		.led            (led),
		.threshold_now  (threshold_now),
		.hysteresis_now (hysteresis_now)
	);

	schd_level_checker #(.SB(SB), .HW(HW)) u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wen        (cfg_wen),
		.cfg_wdata      (cfg_wdata),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.sample         (sample),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.calibrating    (calibrating),
		.level          (level),
		.event_res      (event_res),
		.led            (led),
		.threshold_now  (threshold_now),
		.hysteresis_now (hysteresis_now),
		.mismatches     (mismatches),
		.pending        (pending),
		.n_results      (n_results),
		.n_calib        (n_calib),
		.n_bright       (n_bright),
		.n_dark         (n_dark),
		.thr_pred       (thr_pred),
		.hys_pred       (hys_pred)
	);

	// Receiver: long hold-off on request, otherwise short random stall bursts unless quiet
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (hold_reqs != hold_seen) begin
			hold_seen = hold_reqs;
			hold_left = HOLD_CYCLES - 1;
			out_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (quiet) begin
			out_stall <= 1'b0;
		end else if (burst_left > 0) begin
			burst_left--;
			out_stall <= 1'b1;
		end else if ($urandom_range(5, 0) == 0) begin
			burst_left = $urandom_range(2, 0);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Watchdog: too long without any transfer ends the run
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	function automatic logic [SB-1:0] clip_sample(input int v);
		if (v < 0)
			return '0;
		if (v > SMAX)
			return SB'(SMAX);
		return SB'(v);
	endfunction

	// Calibration samples: bright or dim scene, opening with the field extreme
	function automatic logic [SB-1:0] calib_sample(input bit bright_scene, input bit first);
		if (first)
			return bright_scene ? SB'(SMAX) : '0;
		return bright_scene ? SB'($urandom_range(SMAX, 700)) : SB'($urandom_range(250, 0));
	endfunction

	// One sample transfer, sometimes after a short gap
	task automatic send_sample(input logic [SB-1:0] s);
		if (!quiet && $urandom_range(5, 0) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(3, 1)) @(posedge clk);
		end
		in_valid <= 1'b1;
		sample <= s;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// Let every result come back, allow the block to settle, then write the register
	task automatic settle_and_write(input logic [CFG_W-1:0] v);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_wen <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_wen <= 1'b0;
	endtask

	initial begin
		int            thr;
		int            hys;
		int            pick;
		bit            bright_scene;
		logic [SB-1:0] s;
		int            directed_pts[13];

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Calibration: out-of-range count first, then the largest, then a count
		// already passed, so the closing average may saturate
		bright_scene = $urandom_range(1, 0);
		settle_and_write(LOG2_TOP);
		for (int i = 0; i < 5; i++)
			send_sample(calib_sample(bright_scene, i == 0));
		settle_and_write(LOG2_MAX);
		for (int i = 0; i < 3; i++)
			send_sample(calib_sample(bright_scene, 1'b0));
		settle_and_write(LOG2_SHORT);
		send_sample(calib_sample(bright_scene, 1'b0));

		// a write after calibration must change nothing
		settle_and_write(LOG2_ZERO);
		thr = thr_pred;
		hys = hys_pred;

		// Directed: extremes, band edges, holds, both events and re-entry
		directed_pts = '{0, SMAX, thr + hys + 1, thr + hys, thr, thr - hys, thr - hys - 1,
			thr - hys - 1, thr + hys + 1, SMAX, 0, 'h155, 'h2AA};
		foreach (directed_pts[k])
			send_sample(clip_sample(directed_pts[k]));

		// Random: mostly around the band so that the level keeps switching
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == 300)
				hold_reqs <= hold_reqs + 1;
			if (i == 600)
				settle_and_write(CALIB_LOG2_RST);
			if (i == 900)
				settle_and_write(LOG2_TOP);
			if (i == RANDOM_ITEMS - QUIET_ITEMS)
				quiet <= 1'b1;
			pick = $urandom_range(19, 0);
			if (pick < 12)
				s = SB'($urandom_range(clip_sample(thr + hys + 6), clip_sample(thr - hys - 6)));
			else if (pick < 17)
				s = SB'($urandom_range(SMAX, 0));
			else if (pick == 17)
				s = '0;
			else if (pick == 18)
				s = SB'(SMAX);
			else
				case ($urandom_range(3, 0))
					0: s = clip_sample(thr + hys);
					1: s = clip_sample(thr + hys + 1);
					2: s = clip_sample(thr - hys);
					default: s = clip_sample(thr - hys - 1);
				endcase
			send_sample(s);
		end

		// Drain
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d results, %0d of them in calibration (%s scene)",
			n_results, n_calib, bright_scene ? "bright" : "dim");
		$display("threshold %0d, hysteresis %0d, %0d brighten and %0d darken events",
			thr, hys, n_bright, n_dark);
		if (mismatches == 0 && pending == 0) begin
			$display("end of test: clean");
		end else begin
			if (pending != 0)
				$display("%0t: %0d results never arrived", $time, pending);
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

// File: self_calibrating_hysteresis_detector_unit.f
design/schd_pkg.sv
design/schd_calib.sv
design/schd_detect.sv
design/self_calibrating_hysteresis_detector_unit.sv
dv/schd_level_checker.sv
dv/self_calibrating_hysteresis_detector_unit_tb.sv
